/* rtl/qsd_pkg.sv */
// ============================================================================
// qsd_pkg - shared types and constants for the QAM soft demapper
// Modulation codes, base thresholds in Q3.12 and pipeline advance controls.
// ============================================================================
package qsd_pkg;

    // Modulation order codes, as held in the mode register
    localparam logic [2:0] MOD_BPSK   = 3'd0;
    localparam logic [2:0] MOD_QPSK   = 3'd1;
    localparam logic [2:0] MOD_QAM16  = 3'd2;
    localparam logic [2:0] MOD_QAM64  = 3'd3;
    localparam logic [2:0] MOD_QAM256 = 3'd4;

    localparam logic [2:0] MOD_RESET  = MOD_QPSK;

    // Thresholds in Q3.12, rounded to nearest
    localparam int THR_QAM16_0  = 2591;
    localparam int THR_QAM64_0  = 2528;
    localparam int THR_QAM64_1  = 1264;
    localparam int THR_QAM256_0 = 2513;
    localparam int THR_QAM256_1 = 1257;
    localparam int THR_QAM256_2 = 628;

    // Width of the per-mode count of abs/subtract stages in use
    localparam int STAGE_W = 2;

    // Per-stage advance enables of the symbol pipeline
    typedef struct packed {
        logic st1;
        logic st2;
        logic st3;
        logic out;
    } qsd_adv_t;

    // Rescale a Q3.12 constant to sample_bits-4 fraction bits
    // (left shift when wider, rounded right shift when narrower).
    function automatic int scale_thr(input int t, input int sample_bits);
        int res;
        if (sample_bits >= 16) begin
            res = t << (sample_bits - 16);
        end else begin
            res = (t + (1 << (15 - sample_bits))) >>> (16 - sample_bits);
        end
        return res;
    endfunction

    // Abs/subtract stages in use; undefined codes act as 256-QAM
    function automatic logic [STAGE_W-1:0] num_stages(input logic [2:0] mode);
        logic [STAGE_W-1:0] n;
        unique case (mode)
            MOD_BPSK:  n = 2'd0;
            MOD_QPSK:  n = 2'd0;
            MOD_QAM16: n = 2'd1;
            MOD_QAM64: n = 2'd2;
            default:   n = 2'd3;
        endcase
        return n;
    endfunction

endpackage

/* rtl/qsd_lane.sv */
// ============================================================================
// qsd_lane - one component lane of the soft demapper
// Three abs-minus-threshold steps on one sample (I or Q); the first two are registered.
// ============================================================================
module qsd_lane #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                               aclk,
    input  qsd_pkg::qsd_adv_t                  adv,
    input  logic signed [SAMPLE_BITS-1:0]      sample,
    input  logic [2:0][SAMPLE_BITS-1:0]        thr,
    output logic [3:0][SAMPLE_BITS-1:0]        taps
);

    localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

    logic signed [SAMPLE_BITS-1:0] s1_x0_reg;
    logic signed [SAMPLE_BITS-1:0] s2_x0_reg;
    logic signed [SAMPLE_BITS-1:0] s2_x1_reg;
    logic signed [SAMPLE_BITS-1:0] s3_x0_reg;
    logic signed [SAMPLE_BITS-1:0] s3_x1_reg;
    logic signed [SAMPLE_BITS-1:0] s3_x2_reg;
    logic signed [SAMPLE_BITS-1:0] s2_x1_next;
    logic signed [SAMPLE_BITS-1:0] s3_x2_next;
    logic signed [SAMPLE_BITS-1:0] x3;

    // Absolute value, most negative code saturates to the largest positive
    function automatic logic signed [SAMPLE_BITS-1:0] sat_abs(
        input logic signed [SAMPLE_BITS-1:0] x
    );
        logic signed [SAMPLE_BITS-1:0] r;
        if (x == S_MIN) begin
            r = S_MAX;
        end else if (x < 0) begin
            r = -x;
        end else begin
            r = x;
        end
        return r;
    endfunction

    always_comb begin
        s2_x1_next = sat_abs(s1_x0_reg) - $signed(thr[0]);
        s3_x2_next = sat_abs(s2_x1_reg) - $signed(thr[1]);
        x3         = sat_abs(s3_x2_reg) - $signed(thr[2]);
    end

    always_ff @(posedge aclk) begin
        if (adv.st1) begin
            s1_x0_reg <= sample;
        end
        if (adv.st2) begin
            s2_x0_reg <= s1_x0_reg;
            s2_x1_reg <= s2_x1_next;
        end
        if (adv.st3) begin
            s3_x0_reg <= s2_x0_reg;
            s3_x1_reg <= s2_x1_reg;
            s3_x2_reg <= s3_x2_next;
        end
    end

    assign taps = {x3, s3_x2_reg, s3_x1_reg, s3_x0_reg};

endmodule

/* rtl/qsd_merge.sv */
// ============================================================================
// qsd_merge - output stage of the soft demapper
// Interleaves the I and Q lane taps, zeroes unused soft bits, sets the count.
// ============================================================================
module qsd_merge #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          adv_out,
    input  logic [2:0]                    mode,
    input  logic [3:0][SAMPLE_BITS-1:0]   i_taps,
    input  logic [3:0][SAMPLE_BITS-1:0]   q_taps,
    input  logic                          last_in,
    output logic [7:0][SAMPLE_BITS-1:0]   llr,
    output logic [3:0]                    llr_count,
    output logic                          last_out
);

    logic [7:0][SAMPLE_BITS-1:0]        llr_reg;
    logic [7:0][SAMPLE_BITS-1:0]        llr_next;
    logic [3:0]                         count_reg;
    logic [3:0]                         count_next;
    logic                               last_reg;
    logic [qsd_pkg::STAGE_W-1:0]        stages;

    always_comb begin
        stages = qsd_pkg::num_stages(mode);
        for (int k = 0; k < 4; k++) begin
            llr_next[2*k]   = i_taps[k];
            llr_next[2*k+1] = q_taps[k];
            // drop the pairs beyond the stages in use
            if (k > 0 && k > int'(stages)) begin
                llr_next[2*k]   = '0;
                llr_next[2*k+1] = '0;
            end
        end
        if (mode == qsd_pkg::MOD_BPSK) begin
            llr_next[1] = '0;
            count_next  = 4'd1;
        end else begin
            count_next  = 4'd2 + {1'b0, stages, 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv_out) begin
            llr_reg   <= llr_next;
            count_reg <= count_next;
            last_reg  <= last_in;
        end
    end

    assign llr       = llr_reg;
    assign llr_count = count_reg;
    assign last_out  = last_reg;

endmodule

/* rtl/qam_soft_demapper.sv */
// ============================================================================
// qam_soft_demapper - simplified max-log soft demapper, BPSK to 256-QAM
// An accepted input beat passes registers st1, st2, st3 and out in turn.
// Throughput: one symbol per cycle while m_tready is high.
// Each stage register advances independently, so bubbles are squeezed out;
// a new symbol is taken while a result waits for m_tready if a stage is empty.
// Reset: aresetn (synchronous, active low) clears all stage valid bits and
// loads mod_order with QPSK; payload registers are not reset.
// ============================================================================
module qam_soft_demapper #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,

    // Configuration write channel: mod_order
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [2:0]              cfg_data,

    // Symbol input
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // [SB-1:0] in_phase, [2*SB-1:SB] quadrature, zero padded to bytes
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
    input  logic                    s_tlast,   // last_symbol

    // Soft bit output
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // llr_0 .. llr_7 (SB bits each, from the lowest), then llr_count (4 bits),
    // zero padded to bytes
    output logic [((8*SAMPLE_BITS+4+7)/8)*8-1:0] m_tdata,
    output logic                    m_tlast    // last_out
);

    localparam int M_TDATA_W = ((8*SAMPLE_BITS+4+7)/8)*8;
    localparam int PAD_W     = M_TDATA_W - 8*SAMPLE_BITS - 4;

    // Thresholds rescaled to SAMPLE_BITS-4 fraction bits
    localparam logic [SAMPLE_BITS-1:0] T16_0  =
        SAMPLE_BITS'(qsd_pkg::scale_thr(qsd_pkg::THR_QAM16_0, SAMPLE_BITS));
    localparam logic [SAMPLE_BITS-1:0] T64_0  =
        SAMPLE_BITS'(qsd_pkg::scale_thr(qsd_pkg::THR_QAM64_0, SAMPLE_BITS));
    localparam logic [SAMPLE_BITS-1:0] T64_1  =
        SAMPLE_BITS'(qsd_pkg::scale_thr(qsd_pkg::THR_QAM64_1, SAMPLE_BITS));
    localparam logic [SAMPLE_BITS-1:0] T256_0 =
        SAMPLE_BITS'(qsd_pkg::scale_thr(qsd_pkg::THR_QAM256_0, SAMPLE_BITS));
    localparam logic [SAMPLE_BITS-1:0] T256_1 =
        SAMPLE_BITS'(qsd_pkg::scale_thr(qsd_pkg::THR_QAM256_1, SAMPLE_BITS));
    localparam logic [SAMPLE_BITS-1:0] T256_2 =
        SAMPLE_BITS'(qsd_pkg::scale_thr(qsd_pkg::THR_QAM256_2, SAMPLE_BITS));

    logic [2:0]                   mod_order_reg;
    logic [3:0]                   vld_reg;       // st1, st2, st3, out
    logic [3:0]                   vld_next;
    logic [2:0]                   last_reg;      // last flag beside st1..st3
    qsd_pkg::qsd_adv_t            adv;
    logic                         s_fire;
    logic [2:0][SAMPLE_BITS-1:0]  thr;
    logic [3:0][SAMPLE_BITS-1:0]  i_taps;
    logic [3:0][SAMPLE_BITS-1:0]  q_taps;
    logic [7:0][SAMPLE_BITS-1:0]  llr;
    logic [3:0]                   llr_count;

    // Configuration: always ready; the user writes only while the pipeline is empty (not enforced)
    assign cfg_ready = 1'b1;

    // Stage advance: a stage loads when empty or when the next one loads
    always_comb begin
        adv.out = !vld_reg[3] || m_tready;
        adv.st3 = !vld_reg[2] || adv.out;
        adv.st2 = !vld_reg[1] || adv.st3;
        adv.st1 = !vld_reg[0] || adv.st2;
    end

    assign s_tready = adv.st1;
    assign s_fire   = s_tvalid && s_tready;

    always_comb begin
        vld_next    = vld_reg;
        if (adv.st1) vld_next[0] = s_fire;
        if (adv.st2) vld_next[1] = vld_reg[0];
        if (adv.st3) vld_next[2] = vld_reg[1];
        if (adv.out) vld_next[3] = vld_reg[2];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mod_order_reg <= qsd_pkg::MOD_RESET;
            vld_reg       <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                mod_order_reg <= cfg_data;
            end
            vld_reg <= vld_next;
        end
    end

    // Carry the frame marker beside the lane stages
    always_ff @(posedge aclk) begin
        if (adv.st1) last_reg[0] <= s_tlast;
        if (adv.st2) last_reg[1] <= last_reg[0];
        if (adv.st3) last_reg[2] <= last_reg[1];
    end

    // Per-stage threshold for the current order; stages the mode does not
    // use get any value, their results are dropped at the merge
    always_comb begin
        thr = {T256_2, T256_1, T256_0};
        unique case (mod_order_reg)
            qsd_pkg::MOD_QAM16: thr[0] = T16_0;
            qsd_pkg::MOD_QAM64: begin
                thr[0] = T64_0;
                thr[1] = T64_1;
            end
            default: ;
        endcase
    end

    // In-phase and quadrature lanes run side by side
    qsd_lane #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane_i (
        .aclk   (aclk),
        .adv    (adv),
        .sample (s_tdata[SAMPLE_BITS-1:0]),
        .thr    (thr),
        .taps   (i_taps)
    );

    qsd_lane #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane_q (
        .aclk   (aclk),
        .adv    (adv),
        .sample (s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .thr    (thr),
        .taps   (q_taps)
    );

    // Merge lanes into the output register
    qsd_merge #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_merge (
        .aclk      (aclk),
        .adv_out   (adv.out),
        .mode      (mod_order_reg),
        .i_taps    (i_taps),
        .q_taps    (q_taps),
        .last_in   (last_reg[2]),
        .llr       (llr),
        .llr_count (llr_count),
        .last_out  (m_tlast)
    );

    assign m_tvalid = vld_reg[3];
    assign m_tdata  = {{PAD_W{1'b0}}, llr_count, llr};

endmodule
